FILE: rtl/plist_pkg.sv
// Package: shared widths, request codes, sequencer states and result payload type.
package plist_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int REQ_TYPE_W = 3;
   localparam int POS_W      = 7;
   localparam int VALUE_W    = 32;
   localparam int LEN_W      = 7;

   // Request codes carried in req_type
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_GET    = 3'd0,
      REQ_LOCATE = 3'd1,
      REQ_PRIOR  = 3'd2,
      REQ_NEXT   = 3'd3,
      REQ_INSERT = 3'd4,
      REQ_DELETE = 3'd5
   } req_kind_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_DONE
   } plist_state_type;

   // One finished result, handed from the sequencer to the output register
   typedef struct packed {
      logic               status;
      logic [VALUE_W-1:0] result_value;
      logic [POS_W-1:0]   found_position;
      logic [LEN_W-1:0]   list_length;
      logic               list_empty;
   } rsp_payload_type;

endpackage

FILE: rtl/plist_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface plist_req_if;
   import plist_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_W-1:0]     req_type;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input value,
                   output ready);
endinterface

interface plist_rsp_if;
   import plist_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      status;
   logic signed [VALUE_W-1:0] result_value;
   logic [POS_W-1:0]          found_position;
   logic [LEN_W-1:0]          list_length;
   logic                      list_empty;

   modport source (output valid, output status, output result_value,
                   output found_position, output list_length, output list_empty,
                   input ready);
   modport sink   (input valid, input status, input result_value,
                   input found_position, input list_length, input list_empty,
                   output ready);
endinterface

FILE: rtl/plist_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module plist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/plist_ctrl.sv
// Sequencer: decodes a request, scans or shifts the entry memory, builds the result.
module plist_ctrl #(
   parameter int DEPTH = plist_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   plist_req_if.sink                  req_bus,
   output logic                       done_valid,
   input  logic                       done_ready,
   output plist_pkg::rsp_payload_type done_payload,
   output logic                       ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
   output logic [plist_pkg::VALUE_W-1:0] ram_wr_data,
   output logic                       ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
   input  logic [plist_pkg::VALUE_W-1:0] ram_rd_data
);
   import plist_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   plist_state_type    state_ff, state_in;
   req_kind_type       kind_ff, kind_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      src_ff, src_in;
   logic               have_ff, have_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;
   logic               res_status_ff, res_status_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [POS_W-1:0]   res_found_ff, res_found_in;

   // Helpers in a common compare width
   logic [CMPW-1:0] cnt_ext, req_pos_ext, req_pos_m1, pos_ext, pos_m1;
   logic [CMPW-1:0] idx_ext, src_ext;
   logic [CW-1:0]   idx_dec, idx_inc, src_dec;

   assign cnt_ext     = CMPW'(count_ff);
   assign req_pos_ext = CMPW'(req_bus.position);
   assign req_pos_m1  = req_pos_ext - CMPW'(1);
   assign pos_ext     = CMPW'(pos_ff);
   assign pos_m1      = pos_ext - CMPW'(1);
   assign idx_ext     = CMPW'(idx_ff);
   assign src_ext     = CMPW'(src_ff);
   assign idx_dec     = idx_ff - CW'(1);
   assign idx_inc     = idx_ff + CW'(1);
   assign src_dec     = src_ff - CW'(1);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         have_ff  <= have_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      src_ff        <= src_in;
      prev_ff       <= prev_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
   end

   // Next state, memory accesses and result fields
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      src_in        = src_ff;
      have_in       = have_ff;
      prev_in       = prev_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      req_bus.ready = 1'b0;
      done_valid    = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               kind_in       = req_kind_type'(req_bus.req_type);
               pos_in        = req_bus.position;
               key_in        = req_bus.value;
               have_in       = 1'b0;
               res_status_in = 1'b1;
               res_value_in  = '0;
               res_found_in  = '0;
               state_in      = ST_DONE;
               unique case (req_kind_type'(req_bus.req_type))
                  REQ_GET: begin
                     if (req_pos_ext != '0 && req_pos_ext <= cnt_ext) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_pos_m1[AW-1:0];
                        state_in    = ST_FETCH;
                     end
                  end
                  REQ_LOCATE, REQ_PRIOR, REQ_NEXT: begin
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_INSERT: begin
                     if (cnt_ext < CMPW'(DEPTH) && req_pos_ext != '0 &&
                         req_pos_ext <= cnt_ext + CMPW'(1)) begin
                        idx_in   = count_ff;
                        state_in = ST_SHIFT_UP;
                     end
                  end
                  REQ_DELETE: begin
                     if (req_pos_ext != '0 && req_pos_ext <= cnt_ext) begin
                        idx_in   = req_pos_m1[CW-1:0];
                        state_in = ST_SHIFT_DOWN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // One read issued and one entry compared per cycle
         ST_SCAN: begin
            if (have_ff && ram_rd_data == key_ff) begin
               state_in = ST_DONE;
               have_in  = 1'b0;
               unique case (kind_ff)
                  REQ_LOCATE: begin
                     res_status_in = 1'b0;
                     res_found_in  = idx_ext[POS_W-1:0];
                  end
                  REQ_PRIOR: begin
                     if (idx_ff >= CW'(2)) begin
                        res_status_in = 1'b0;
                        res_value_in  = prev_ff;
                     end
                  end
                  REQ_NEXT: begin
                     if (idx_ff < count_ff) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_ff[AW-1:0];
                        state_in    = ST_FETCH;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end else begin
               if (have_ff) begin
                  prev_in = ram_rd_data;
               end
               if (idx_ff < count_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff[AW-1:0];
                  idx_in      = idx_inc;
                  have_in     = 1'b1;
               end else begin
                  have_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end

         // Read data lands; value returned by get and next
         ST_FETCH: begin
            res_status_in = 1'b0;
            res_value_in  = ram_rd_data;
            state_in      = ST_DONE;
         end

         // Insert: move entries up from the tail, then write the new value
         ST_SHIFT_UP: begin
            if (have_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = src_ff[AW-1:0];
               ram_wr_data = ram_rd_data;
            end
            if (idx_ext >= pos_ext) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_dec[AW-1:0];
               src_in      = idx_ff;
               idx_in      = idx_dec;
               have_in     = 1'b1;
            end else begin
               have_in = 1'b0;
               if (!have_ff) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = pos_m1[AW-1:0];
                  ram_wr_data   = key_ff;
                  count_in      = count_ff + CW'(1);
                  res_status_in = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end

         // Delete: capture the removed entry, move the rest down by one
         ST_SHIFT_DOWN: begin
            if (have_ff) begin
               if (src_ext == pos_m1) begin
                  res_value_in = ram_rd_data;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = src_dec[AW-1:0];
                  ram_wr_data = ram_rd_data;
               end
            end
            if (idx_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[AW-1:0];
               src_in      = idx_ff;
               idx_in      = idx_inc;
               have_in     = 1'b1;
            end else begin
               have_in = 1'b0;
               if (!have_ff) begin
                  count_in      = count_ff - CW'(1);
                  res_status_in = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result payload
   assign done_payload.status         = res_status_ff;
   assign done_payload.result_value   = res_value_ff;
   assign done_payload.found_position = res_found_ff;
   assign done_payload.list_length    = cnt_ext[LEN_W-1:0];
   assign done_payload.list_empty     = (count_ff == '0);

endmodule

FILE: rtl/positional_list_engine.sv
// Top level: positional list engine with entry memory, sequencer and response register.
//
// Keeps one ordered list of signed 32-bit values, up to DEPTH entries, in a
// single synchronous memory with one write and one registered read port.
// Positions count from 1. One request is worked at a time; the next request
// is taken as soon as the previous result has moved to the response register,
// even while that result still waits on rsp_bus.ready. Locate, prior and next
// compare one entry per cycle; insert and delete move the entries from the
// position onward one at a time, since the memory has a single read port and
// a single write port, and an append at the end moves none. No clearing pass is
// needed after reset: only entries below the length are ever read.
module positional_list_engine #(
   parameter int DEPTH = plist_pkg::DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   plist_req_if.sink   req_bus,
   plist_rsp_if.source rsp_bus
);
   import plist_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic               done_valid;
   logic               done_ready;
   rsp_payload_type    done_payload;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;
   logic               rsp_load;

   plist_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   plist_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .done_valid   (done_valid),
      .done_ready   (done_ready),
      .done_payload (done_payload),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   // Response register: takes a result when empty or being drained
   assign done_ready = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load   = done_valid && done_ready;

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = done_payload;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_payload_ff.status;
   assign rsp_bus.result_value   = rsp_payload_ff.result_value;
   assign rsp_bus.found_position = rsp_payload_ff.found_position;
   assign rsp_bus.list_length    = rsp_payload_ff.list_length;
   assign rsp_bus.list_empty     = rsp_payload_ff.list_empty;

endmodule

FILE: verif/positional_list_engine_test.sv
// Testbench: positional list engine checked against a queue-based list predictor.
module positional_list_engine_test;
   import plist_pkg::*;

   localparam int DEPTH = plist_pkg::DEPTH_DEFAULT;
   // request codes the block does not implement
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = DEPTH + 10;
   localparam int MAX_PRINTS = 40;

   logic clock;
   logic reset;

   plist_req_if req_bus ();
   plist_rsp_if rsp_bus ();

   positional_list_engine #(.DEPTH(DEPTH)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted list contents and results still owed by the block
   logic signed [VALUE_W-1:0] list_model[$];
   rsp_payload_type           pending_results[$];

   int error_count = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int rsp_hold_cycles = 0;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #6000000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch @%0t: %s", $realtime, msg);
   endtask

   // first one-based position holding v, 0 when absent
   function automatic int first_position(logic signed [VALUE_W-1:0] v);
      foreach (list_model[k])
         if (list_model[k] == v)
            return k + 1;
      return 0;
   endfunction

   // apply one request to the list model and build the expected transaction
   function automatic rsp_payload_type apply_list_request(logic [REQ_TYPE_W-1:0] code,
                                                          logic [POS_W-1:0] pos,
                                                          logic signed [VALUE_W-1:0] val);
      rsp_payload_type r;
      int p;
      int n;
      int hit;
      r = '0;
      r.status = 1'b1;
      p = pos;
      n = list_model.size();
      case (code)
         REQ_GET: begin
            if (p >= 1 && p <= n) begin
               r.result_value = list_model[p-1];
               r.status = 1'b0;
            end
         end
         REQ_LOCATE: begin
            hit = first_position(val);
            r.found_position = POS_W'(hit);
            r.status = (hit == 0);
         end
         REQ_PRIOR: begin
            hit = first_position(val);
            if (hit >= 2) begin
               r.result_value = list_model[hit-2];
               r.status = 1'b0;
            end
         end
         REQ_NEXT: begin
            hit = first_position(val);
            if (hit != 0 && hit < n) begin
               r.result_value = list_model[hit];
               r.status = 1'b0;
            end
         end
         REQ_INSERT: begin
            if (n < DEPTH && p >= 1 && p <= n + 1) begin
               list_model.insert(p - 1, val);
               r.status = 1'b0;
            end
         end
         REQ_DELETE: begin
            if (p >= 1 && p <= n) begin
               r.result_value = list_model[p-1];
               list_model.delete(p - 1);
               r.status = 1'b0;
            end
         end
         default: ;
      endcase
      r.list_length = LEN_W'(list_model.size());
      r.list_empty = (list_model.size() == 0);
      return r;
   endfunction

   // send one request; valid stays high afterwards unless the next call idles
   task automatic issue_request(logic [REQ_TYPE_W-1:0] code, logic [POS_W-1:0] pos,
                                logic signed [VALUE_W-1:0] val);
      int gap;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= code;
      req_bus.position <= pos;
      req_bus.value    <= val;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_list_request(code, pos, val));
   endtask

   // drop valid and wait until every owed transaction has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls per transaction, plus an occasional long hold
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            stall = receiver_idles ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && !reset));
      end
   end

   // result checker
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transaction with nothing pending");
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %b, want %b", rsp_bus.status, want.status));
            if (rsp_bus.result_value !== want.result_value)
               report_mismatch($sformatf("result_value %h, want %h",
                                         rsp_bus.result_value, want.result_value));
            if (rsp_bus.found_position !== want.found_position)
               report_mismatch($sformatf("found_position %0d, want %0d",
                                         rsp_bus.found_position, want.found_position));
            if (rsp_bus.list_length !== want.list_length)
               report_mismatch($sformatf("list_length %0d, want %0d",
                                         rsp_bus.list_length, want.list_length));
            if (rsp_bus.list_empty !== want.list_empty)
               report_mismatch($sformatf("list_empty %b, want %b",
                                         rsp_bus.list_empty, want.list_empty));
         end
      end
   end

   // value source: often one already in the list so searches hit
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && list_model.size() > 0)
         return list_model[$urandom_range(0, list_model.size() - 1)];
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      if (r < 70)
         return $urandom_range(0, 7);
      return $urandom;
   endfunction

   // position source: mostly in range, sometimes zero or anywhere
   function automatic logic [POS_W-1:0] pick_position(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80 && span >= 1)
         return POS_W'($urandom_range(1, span));
      if (r < 90)
         return '0;
      return POS_W'($urandom_range(0, 127));
   endfunction

   // requests against an empty list
   task automatic test_empty_list();
      issue_request(REQ_GET, 7'd1, 32'sd0);
      issue_request(REQ_GET, 7'd0, 32'sd0);
      issue_request(REQ_DELETE, 7'd1, 32'sd0);
      issue_request(REQ_LOCATE, 7'd0, 32'sd0);
      issue_request(REQ_PRIOR, 7'd0, 32'sd0);
      issue_request(REQ_NEXT, 7'd0, 32'sd0);
      issue_request(REQ_INSERT, 7'd2, 32'sd9);
      issue_request(REQ_INSERT, 7'd0, 32'sd9);
      wait_for_results();
   endtask

   // every request kind, value extremes, duplicates and neighbors at the ends
   task automatic test_basic_edits();
      issue_request(REQ_INSERT, 7'd1, 32'sh8000_0000);
      issue_request(REQ_INSERT, 7'd2, 32'sh7fff_ffff);
      issue_request(REQ_INSERT, 7'd2, 32'sd5);
      issue_request(REQ_INSERT, 7'd1, 32'sd5);
      issue_request(REQ_LOCATE, 7'd0, 32'sd5);
      issue_request(REQ_LOCATE, 7'd0, 32'sd77);
      issue_request(REQ_PRIOR, 7'd0, 32'sd5);
      issue_request(REQ_NEXT, 7'd0, 32'sd5);
      issue_request(REQ_PRIOR, 7'd0, 32'sh7fff_ffff);
      issue_request(REQ_NEXT, 7'd0, 32'sh7fff_ffff);
      issue_request(REQ_GET, 7'd4, 32'sd0);
      issue_request(REQ_GET, 7'd5, 32'sd0);
      issue_request(REQ_GET, 7'd127, -32'sd1);
      issue_request(REQ_DELETE, 7'd2, 32'sd0);
      issue_request(REQ_INSERT, 7'd127, -32'sd1);
      issue_request(REQ_SPARE_LO, 7'd1, 32'sd5);
      issue_request(REQ_SPARE_HI, 7'd127, -32'sd1);
      issue_request(REQ_DELETE, 7'd1, 32'sd0);
      wait_for_results();
   endtask

   // grow to capacity, push past it, then shrink back down
   task automatic test_fill_to_capacity();
      logic signed [VALUE_W-1:0] last_value;
      while (list_model.size() < DEPTH)
         issue_request(REQ_INSERT, POS_W'($urandom_range(1, list_model.size() + 1)),
                       pick_value());
      issue_request(REQ_INSERT, 7'd1, 32'sd3);
      issue_request(REQ_INSERT, POS_W'(DEPTH + 1), 32'sd3);
      issue_request(REQ_GET, POS_W'(DEPTH), 32'sd0);
      last_value = list_model[DEPTH-1];
      issue_request(REQ_LOCATE, 7'd0, last_value);
      issue_request(REQ_NEXT, 7'd0, last_value);
      issue_request(REQ_PRIOR, 7'd0, last_value);
      issue_request(REQ_DELETE, POS_W'(DEPTH), 32'sd0);
      while (list_model.size() > 8)
         issue_request(REQ_DELETE, POS_W'($urandom_range(1, list_model.size())), 32'sd0);
      wait_for_results();
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      sender_idles = 1'b0;
      rsp_hold_cycles = 200;
      repeat (20) begin
         if ($urandom_range(0, 1))
            issue_request(REQ_INSERT, pick_position(list_model.size() + 1), pick_value());
         else
            issue_request(REQ_LOCATE, pick_position(list_model.size()), pick_value());
      end
      wait_for_results();
      sender_idles = 1'b1;
   endtask

   // random request mix; the list length drifts around target
   task automatic run_random_mix(int count, int target, bit tx_idle, bit rx_idle);
      int r;
      int n;
      sender_idles = tx_idle;
      receiver_idles = rx_idle;
      repeat (count) begin
         r = $urandom_range(0, 99);
         n = list_model.size();
         if (r < 3)
            issue_request($urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI,
                          POS_W'($urandom_range(0, 127)), $urandom);
         else if (r < 18)
            issue_request(REQ_GET, pick_position(n), $urandom);
         else if (r < 33)
            issue_request(REQ_LOCATE, POS_W'($urandom_range(0, 127)), pick_value());
         else if (r < 45)
            issue_request(REQ_PRIOR, POS_W'($urandom_range(0, 127)), pick_value());
         else if (r < 57)
            issue_request(REQ_NEXT, POS_W'($urandom_range(0, 127)), pick_value());
         else if ($urandom_range(0, 2 * target) >= n)
            issue_request(REQ_INSERT, pick_position(n + 1), pick_value());
         else
            issue_request(REQ_DELETE, pick_position(n), $urandom);
      end
      wait_for_results();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // test sequence
   initial begin
      req_bus.valid    = 1'b0;
      req_bus.req_type = '0;
      req_bus.position = '0;
      req_bus.value    = '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      test_empty_list();
      test_basic_edits();
      test_fill_to_capacity();
      test_backpressure();
      run_random_mix(150, 8, 1'b1, 1'b1);
      run_random_mix(110, 32, 1'b0, 1'b0);
      run_random_mix(110, 60, 1'b1, 1'b0);
      run_random_mix(110, 20, 1'b0, 1'b1);
      run_random_mix(100, 40, 1'b1, 1'b1);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
rtl/plist_pkg.sv
rtl/plist_if.sv
rtl/plist_ram.sv
rtl/plist_ctrl.sv
rtl/positional_list_engine.sv
verif/positional_list_engine_test.sv
